### design/rfpd_pkg.sv
// Shared types and constants for the RF remote pulse decoder.
package rfpd_pkg;

    localparam int TICK_W = 16;
    localparam int CODE_W = 24;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_BITS_DEF = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LOW_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_HIGH_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TIMEOUT = 3'd4;

    // Register reset values
    localparam logic [TICK_W-1:0] IDLE_LOW_TIMEOUT_RST = 16'd16000;
    localparam logic [TICK_W-1:0] LEAD_HIGH_TIMEOUT_RST = 16'd3000;
    localparam logic [TICK_W-1:0] SYNC_LOW_MIN_RST = 16'd10000;
    localparam logic [TICK_W-1:0] SYNC_LOW_MAX_RST = 16'd15000;
    localparam logic [TICK_W-1:0] BIT_TIMEOUT_RST = 16'd2050;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IDLE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LEAD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SYNC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_BIT = 3'd4;

    typedef struct packed {
        logic [TICK_W-1:0] idle_low_timeout;
        logic [TICK_W-1:0] lead_high_timeout;
        logic [TICK_W-1:0] sync_low_min;
        logic [TICK_W-1:0] sync_low_max;
        logic [TICK_W-1:0] bit_timeout;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

### design/rfpd_cfg_regs.sv
// Configuration register file of the pulse decoder.
module rfpd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfpd_pkg::TICK_W-1:0]     i_cfg_data,
    output rfpd_pkg::t_cfg                  o_cfg
);
    import rfpd_pkg::*;

    t_cfg r_cfg;

    // Write one register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_low_timeout  <= IDLE_LOW_TIMEOUT_RST;
            r_cfg.lead_high_timeout <= LEAD_HIGH_TIMEOUT_RST;
            r_cfg.sync_low_min      <= SYNC_LOW_MIN_RST;
            r_cfg.sync_low_max      <= SYNC_LOW_MAX_RST;
            r_cfg.bit_timeout       <= BIT_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IDLE_LOW_TIMEOUT:  r_cfg.idle_low_timeout  <= i_cfg_data;
                REG_LEAD_HIGH_TIMEOUT: r_cfg.lead_high_timeout <= i_cfg_data;
                REG_SYNC_LOW_MIN:      r_cfg.sync_low_min      <= i_cfg_data;
                REG_SYNC_LOW_MAX:      r_cfg.sync_low_max      <= i_cfg_data;
                REG_BIT_TIMEOUT:       r_cfg.bit_timeout       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/rfpd_decode.sv
// Pulse-width decode state machine: one pin sample per accepted transaction.
module rfpd_decode #(
    parameter int CODE_BITS = rfpd_pkg::CODE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_pin_level,
    input  rfpd_pkg::t_cfg     i_cfg,
    output rfpd_pkg::t_result  o_result
);
    import rfpd_pkg::*;

    localparam int IDX_W = 5;
    localparam logic [IDX_W:0] LAST_COUNT = (IDX_W+1)'(CODE_BITS);

    localparam logic [2:0] PH_IDLE_LOW = 3'd0;
    localparam logic [2:0] PH_LEAD_HIGH = 3'd1;
    localparam logic [2:0] PH_SYNC_LOW = 3'd2;
    localparam logic [2:0] PH_BIT_HIGH = 3'd3;
    localparam logic [2:0] PH_BIT_LOW = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_sync, n_sync;
    logic [CODE_W-1:0] r_shift, n_shift;
    logic [IDX_W-1:0]  r_idx, n_idx;

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] t_idle;
    logic [TICK_W-1:0] t_idle_inc;
    logic [TICK_W-1:0] th_lo, th_mid, th_hi;
    logic [IDX_W:0]    idx_next;
    logic              fail;
    logic              done;
    logic [STATUS_W-1:0] fail_status;

    // Saturating tick counts and adaptive bit thresholds
    assign tick_inc   = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign t_idle     = (r_phase == PH_IDLE_LOW) ? r_tick : '0;
    assign t_idle_inc = (t_idle == '1) ? t_idle : t_idle + 1'b1;
    assign th_lo      = r_sync >> 7;
    assign th_mid     = r_sync >> 4;
    assign th_hi      = r_sync >> 3;
    assign idx_next   = {1'b0, r_idx} + 1'b1;

    // Next state for the sample being accepted
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_sync      = r_sync;
        n_shift     = r_shift;
        n_idx       = r_idx;
        fail        = 1'b0;
        done        = 1'b0;
        fail_status = ST_OK;
        if (i_accept) begin
            unique case (r_phase)
                PH_LEAD_HIGH: begin
                    if (i_pin_level && r_tick <= i_cfg.lead_high_timeout) begin
                        n_tick = tick_inc;
                    end else if (r_tick > i_cfg.lead_high_timeout) begin
                        fail        = 1'b1;
                        fail_status = ST_LEAD;
                    end else begin
                        n_phase = PH_SYNC_LOW;
                        n_tick  = '0;
                    end
                end
                PH_SYNC_LOW: begin
                    if (!i_pin_level && r_tick <= i_cfg.sync_low_max) begin
                        n_tick = tick_inc;
                    end else if (r_tick > i_cfg.sync_low_max ||
                                 r_tick < i_cfg.sync_low_min) begin
                        fail        = 1'b1;
                        fail_status = ST_SYNC;
                    end else begin
                        n_sync  = r_tick;
                        n_idx   = '0;
                        n_shift = '0;
                        n_phase = PH_BIT_HIGH;
                        n_tick  = '0;
                    end
                end
                PH_BIT_HIGH: begin
                    if (i_pin_level && r_tick < i_cfg.bit_timeout) begin
                        n_tick = tick_inc;
                    end else if (r_tick > th_lo && r_tick < th_mid) begin
                        n_shift = {r_shift[CODE_W-2:0], 1'b0};
                        n_phase = PH_BIT_LOW;
                        n_tick  = '0;
                    end else if (r_tick > th_mid && r_tick < th_hi) begin
                        n_shift = {r_shift[CODE_W-2:0], 1'b1};
                        n_phase = PH_BIT_LOW;
                        n_tick  = '0;
                    end else begin
                        fail        = 1'b1;
                        fail_status = ST_BAD_BIT;
                    end
                end
                PH_BIT_LOW: begin
                    if (!i_pin_level && r_tick < i_cfg.bit_timeout) begin
                        n_tick = tick_inc;
                    end else if (r_tick >= i_cfg.bit_timeout) begin
                        fail        = 1'b1;
                        fail_status = ST_BAD_BIT;
                    end else if (idx_next >= LAST_COUNT) begin
                        done = 1'b1;
                    end else begin
                        n_idx   = idx_next[IDX_W-1:0];
                        n_phase = PH_BIT_HIGH;
                        n_tick  = '0;
                    end
                end
                default: begin
                    // Idle low wait; a meaningless phase code restarts first
                    n_phase = PH_IDLE_LOW;
                    n_tick  = '0;
                    n_sync  = '0;
                    n_shift = '0;
                    n_idx   = '0;
                    if (!i_pin_level && t_idle <= i_cfg.idle_low_timeout) begin
                        n_tick = t_idle_inc;
                    end else if (t_idle > i_cfg.idle_low_timeout) begin
                        fail        = 1'b1;
                        fail_status = ST_IDLE;
                    end else begin
                        n_phase = PH_LEAD_HIGH;
                    end
                end
            endcase
            // Restart after any result
            if (fail || done) begin
                n_phase = PH_IDLE_LOW;
                n_tick  = '0;
                n_sync  = '0;
                n_shift = '0;
                n_idx   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE_LOW;
            r_tick  <= '0;
            r_sync  <= '0;
            r_shift <= '0;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_sync  <= n_sync;
            r_shift <= n_shift;
            r_idx   <= n_idx;
        end
    end

    // Result of this sample, handed to the output buffer
    assign o_result.valid  = fail || done;
    assign o_result.code   = done ? r_shift : '0;
    assign o_result.status = fail ? fail_status : ST_OK;

endmodule

### design/rfpd_out_buf.sv
// Output register with skid stage for decoded results.
module rfpd_out_buf (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rfpd_pkg::t_result              i_result,
    output logic                           o_space,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rfpd_pkg::CODE_W-1:0]    o_code,
    output logic [rfpd_pkg::STATUS_W-1:0]  o_status
);
    import rfpd_pkg::*;

    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out.valid && i_out_ready;

    // Fill the out register first, the skid when out is held; payload moves with valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (r_skid.valid) begin
            if (pop) begin
                r_skid.valid <= 1'b0;
                r_out.code   <= r_skid.code;
                r_out.status <= r_skid.status;
            end
        end else if (i_result.valid) begin
            if (!r_out.valid || pop) begin
                r_out.valid  <= 1'b1;
                r_out.code   <= i_result.code;
                r_out.status <= i_result.status;
            end else begin
                r_skid.valid  <= 1'b1;
                r_skid.code   <= i_result.code;
                r_skid.status <= i_result.status;
            end
        end else if (pop) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_space     = !r_skid.valid;
    assign o_out_valid = r_out.valid;
    assign o_code      = r_out.code;
    assign o_status    = r_out.status;

endmodule

### design/rf_remote_pulse_decoder_core.sv
// Top level of the RF remote pulse-width code decoder.
// One receiver sample is taken per transaction on the input channel and
// each sample is fully processed by the decode state machine as it is
// accepted, so a sample can be accepted every cycle unless the input stalls.
// A code word or a failure produces one result on the output channel,
// registered with a skid stage; the input stalls only when both output and
// skid registers hold results. Configuration registers (indexes 0 to 4:
// idle low timeout, lead high timeout, sync low minimum, sync low maximum,
// bit timeout) are to be written by the user only while the decoder is
// idle; the block itself does not enforce this.
module rf_remote_pulse_decoder_core #(
    parameter int CODE_BITS = rfpd_pkg::CODE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_pin_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rfpd_pkg::CODE_W-1:0]    o_code,
    output logic [rfpd_pkg::STATUS_W-1:0]  o_status,
    input  logic                           i_cfg_we,
    input  logic [rfpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rfpd_pkg::TICK_W-1:0]    i_cfg_data
);
    import rfpd_pkg::*;

    t_cfg    cfg;
    t_result result;
    logic    space;
    logic    accept;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    rfpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rfpd_decode #(
        .CODE_BITS (CODE_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    rfpd_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code      (o_code),
        .o_status    (o_status)
    );

endmodule

### design/rfpd_checker.sv
// Port-level checks for the pulse decoder, bound to the top level.
module rfpd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [rfpd_pkg::CODE_W-1:0]    o_code,
    input logic [rfpd_pkg::STATUS_W-1:0]  o_status
);
    import rfpd_pkg::*;

    // Status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_BAD_BIT))
        else $error("status code out of range");

    // Failures carry a zero code
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_code == '0))
        else $error("failure result with nonzero code");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // Reset empties the output path
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output not empty after reset");

    // Held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_code) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind rf_remote_pulse_decoder_core rfpd_checker u_rfpd_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the RF remote pulse-width code decoder.
`timescale 1ns / 1ps

module testbench;
    import rfpd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    // Bit thresholds are the sync length shifted down by these amounts
    localparam int LO_SHIFT = 7;
    localparam int MID_SHIFT = 4;
    localparam int HI_SHIFT = 3;

    typedef enum logic [2:0] {
        DEC_IDLE_LOW,
        DEC_LEAD_HIGH,
        DEC_SYNC_LOW,
        DEC_BIT_HIGH,
        DEC_BIT_LOW
    } t_dec_phase;

    typedef enum int {
        FRAME_GOOD,
        FAIL_IDLE,
        FAIL_LEAD,
        FAIL_SYNC,
        FAIL_BIT_HIGH,
        FAIL_BIT_LOW
    } t_frame_fault;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_pin_level = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CODE_W-1:0]    o_code;
    logic [STATUS_W-1:0]  o_status;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TICK_W-1:0]    i_cfg_data = '0;

    // Stimulus side
    logic pin_samples[$];
    int   send_gap_pct = 35;
    int   recv_stall_pct = 57;
    int   plan_idle, plan_lead, plan_smin, plan_smax, plan_bit;

    // Decoder model state and its copy of the registers
    t_frame_result     frame_results_due[$];
    logic [TICK_W-1:0] cfg_idle_lim, cfg_lead_lim, cfg_sync_min, cfg_sync_max, cfg_bit_lim;
    t_dec_phase        dec_phase;
    logic [TICK_W-1:0] tick_cnt;
    logic [TICK_W-1:0] sync_len;
    logic [CODE_W-1:0] code_acc;
    logic [4:0]        bit_cnt;

    int mismatches = 0;
    int quiet_cycles = 0;

    rf_remote_pulse_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pin_level (i_pin_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code      (o_code),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------

    task automatic clear_frame();
        dec_phase = DEC_IDLE_LOW;
        tick_cnt = '0;
        sync_len = '0;
        code_acc = '0;
        bit_cnt = '0;
    endtask

    task automatic post_result(input logic [CODE_W-1:0] word, input logic [STATUS_W-1:0] st);
        frame_results_due.push_back('{code: word, status: st});
        clear_frame();
    endtask

    task automatic enter_phase(input t_dec_phase next);
        dec_phase = next;
        tick_cnt = '0;
    endtask

    task automatic count_tick();
        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    endtask

    // Advance the decoder by one pin sample; queue a result when a frame ends
    task automatic decode_sample(input logic level);
        logic [TICK_W-1:0] t;
        logic [TICK_W-1:0] lo_w, mid_w, hi_w;
        t = tick_cnt;
        lo_w = sync_len >> LO_SHIFT;
        mid_w = sync_len >> MID_SHIFT;
        hi_w = sync_len >> HI_SHIFT;
        case (dec_phase)
            DEC_LEAD_HIGH: begin
                if (level && t <= cfg_lead_lim) count_tick();
                else if (t > cfg_lead_lim) post_result('0, ST_LEAD);
                else enter_phase(DEC_SYNC_LOW);
            end
            DEC_SYNC_LOW: begin
                if (!level && t <= cfg_sync_max) begin
                    count_tick();
                end else if (t > cfg_sync_max || t < cfg_sync_min) begin
                    post_result('0, ST_SYNC);
                end else begin
                    sync_len = t;
                    bit_cnt = '0;
                    code_acc = '0;
                    enter_phase(DEC_BIT_HIGH);
                end
            end
            DEC_BIT_HIGH: begin
                if (level && t < cfg_bit_lim) begin
                    count_tick();
                end else if (t > lo_w && t < mid_w) begin
                    code_acc = {code_acc[CODE_W-2:0], 1'b0};
                    enter_phase(DEC_BIT_LOW);
                end else if (t > mid_w && t < hi_w) begin
                    code_acc = {code_acc[CODE_W-2:0], 1'b1};
                    enter_phase(DEC_BIT_LOW);
                end else begin
                    post_result('0, ST_BAD_BIT);
                end
            end
            DEC_BIT_LOW: begin
                if (!level && t < cfg_bit_lim) begin
                    count_tick();
                end else if (t >= cfg_bit_lim) begin
                    post_result('0, ST_BAD_BIT);
                end else if (int'(bit_cnt) + 1 >= CODE_BITS_DEF) begin
                    post_result(code_acc, ST_OK);
                end else begin
                    bit_cnt = bit_cnt + 1'b1;
                    enter_phase(DEC_BIT_HIGH);
                end
            end
            default: begin
                if (!level && t <= cfg_idle_lim) count_tick();
                else if (t > cfg_idle_lim) post_result('0, ST_IDLE);
                else enter_phase(DEC_LEAD_HIGH);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------

    function automatic int cap(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    task automatic push_level(input logic level, input int n);
        for (int k = 0; k < n; k++) pin_samples.push_back(level);
    endtask

    // Level length up to a limit; for limits up to 40, hit the limit itself now and then
    function automatic int pick_len(input int limit);
        if (limit <= 40 && $urandom_range(3, 0) == 0) return limit;
        return $urandom_range(cap(limit, 12), 0);
    endfunction

    // High width that encodes one bit for a given sync length
    function automatic int bit_width(input logic one, input int sync_ticks);
        int lo_w, mid_w, hi_w, a, b;
        lo_w = sync_ticks >> LO_SHIFT;
        mid_w = sync_ticks >> MID_SHIFT;
        hi_w = sync_ticks >> HI_SHIFT;
        if (one) begin
            a = mid_w + 1;
            b = hi_w - 1;
        end else begin
            a = lo_w + 1;
            b = mid_w - 1;
        end
        b = cap(b, plan_bit - 1);
        // no legal width: the bit gets rejected
        if (a > b) return lo_w;
        case ($urandom_range(3, 0))
            0: return a;
            1: return b;
            default: return $urandom_range(b, a);
        endcase
    endfunction

    // Queue one frame; a faulty frame stops at the sample that breaks it
    task automatic add_frame(input logic [CODE_W-1:0] word, input t_frame_fault fault,
                             input int fault_bit);
        int s, h;
        // idle low, ended by a high
        if (fault == FAIL_IDLE) begin
            push_level(1'b0, plan_idle + 1);
            push_level(1'($urandom_range(1, 0)), 1);
            return;
        end
        push_level(1'b0, pick_len(plan_idle));
        push_level(1'b1, 1);
        // lead high, ended by a low
        if (fault == FAIL_LEAD) begin
            push_level(1'b1, plan_lead + 1);
            push_level(1'($urandom_range(1, 0)), 1);
            return;
        end
        push_level(1'b1, pick_len(plan_lead));
        push_level(1'b0, 1);
        // sync low, ended by a high
        if (plan_smin > plan_smax) begin
            push_level(1'b0, $urandom_range(cap(plan_smax, 60), 0));
            push_level(1'b1, 1);
            return;
        end
        if (fault == FAIL_SYNC) begin
            if ($urandom_range(1, 0) == 0) begin
                push_level(1'b0, plan_smin - 1 - $urandom_range(cap(plan_smin - 1, 3), 0));
                push_level(1'b1, 1);
            end else begin
                push_level(1'b0, plan_smax + 1);
                push_level(1'($urandom_range(1, 0)), 1);
            end
            return;
        end
        case ($urandom_range(3, 0))
            0: s = plan_smin;
            1: s = plan_smax;
            default: s = $urandom_range(cap(plan_smax, plan_smin + 60), plan_smin);
        endcase
        push_level(1'b0, s);
        push_level(1'b1, 1);
        // data bits, first bit most significant
        for (int b = 0; b < CODE_BITS_DEF; b++) begin
            if (fault == FAIL_BIT_HIGH && b == fault_bit) begin
                case ($urandom_range(5, 0))
                    0: h = s >> LO_SHIFT;
                    1: h = s >> MID_SHIFT;
                    2: h = s >> HI_SHIFT;
                    3: h = 0;
                    4: h = (s >> HI_SHIFT) + $urandom_range(3, 0);
                    default: h = plan_bit;
                endcase
                push_level(1'b1, h);
                push_level(1'b0, 1);
                return;
            end
            push_level(1'b1, bit_width(word[CODE_BITS_DEF-1-b], s));
            push_level(1'b0, 1);
            if (fault == FAIL_BIT_LOW && b == fault_bit) begin
                push_level(1'b0, plan_bit);
                push_level(1'($urandom_range(1, 0)), 1);
                return;
            end
            push_level(1'b0, $urandom_range(cap(plan_bit - 1, 10), 0));
            push_level(1'b1, 1);
        end
    endtask

    // Mostly well-formed frames with random codes, some broken ones, some noise
    task automatic add_random_traffic(input int frames);
        t_frame_fault fault;
        bit           allow_long;
        allow_long = plan_idle <= 400 && plan_lead <= 400 && plan_smax <= 400 && plan_bit <= 400;
        repeat (frames) begin
            case ($urandom_range(9, 0))
                6, 7: begin
                    fault = t_frame_fault'($urandom_range(int'(FAIL_BIT_LOW), int'(FAIL_IDLE)));
                    if (!allow_long) fault = FRAME_GOOD;
                    add_frame(CODE_W'($urandom()), fault, $urandom_range(CODE_BITS_DEF - 1, 0));
                end
                8: begin
                    repeat ($urandom_range(30, 1))
                        push_level(1'($urandom_range(1, 0)), $urandom_range(8, 1));
                end
                default: add_frame(CODE_W'($urandom()), FRAME_GOOD, 0);
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= TICK_W'(val);
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input int idle_lim, input int lead_lim, input int smin,
                                input int smax, input int bit_lim);
        write_reg(REG_IDLE_LOW_TIMEOUT, idle_lim);
        write_reg(REG_LEAD_HIGH_TIMEOUT, lead_lim);
        write_reg(REG_SYNC_LOW_MIN, smin);
        write_reg(REG_SYNC_LOW_MAX, smax);
        write_reg(REG_BIT_TIMEOUT, bit_lim);
        end_writes();
        plan_idle = idle_lim;
        plan_lead = lead_lim;
        plan_smin = smin;
        plan_smax = smax;
        plan_bit = bit_lim;
        @(negedge i_clk);
    endtask

    // Hold until every sample is taken and every result has come back
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pin_samples.size() != 0 || i_in_valid || frame_results_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Driver, receiver, monitor, watchdog
    // ---------------------------------------------------------------

    // Present the next pin sample, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pin_samples.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
                i_in_valid <= 1'b1;
                i_pin_level <= pin_samples.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Check results first, then track register writes and accepted samples
    always @(posedge i_clk) begin
        t_frame_result due;
        if (!i_rst_n) begin
            cfg_idle_lim = IDLE_LOW_TIMEOUT_RST;
            cfg_lead_lim = LEAD_HIGH_TIMEOUT_RST;
            cfg_sync_min = SYNC_LOW_MIN_RST;
            cfg_sync_max = SYNC_LOW_MAX_RST;
            cfg_bit_lim = BIT_TIMEOUT_RST;
            clear_frame();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (frame_results_due.size() == 0) begin
                    $error("unexpected result: code %h status %0d", o_code, o_status);
                    mismatches++;
                end else begin
                    due = frame_results_due.pop_front();
                    if (o_code !== due.code) begin
                        $error("code: expected %h, got %h", due.code, o_code);
                        mismatches++;
                    end
                    if (o_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, o_status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IDLE_LOW_TIMEOUT: cfg_idle_lim = i_cfg_data;
                    REG_LEAD_HIGH_TIMEOUT: cfg_lead_lim = i_cfg_data;
                    REG_SYNC_LOW_MIN: cfg_sync_min = i_cfg_data;
                    REG_SYNC_LOW_MAX: cfg_sync_max = i_cfg_data;
                    REG_BIT_TIMEOUT: cfg_bit_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) decode_sample(i_pin_level);
        end
    end

    // Stop the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL rf_remote_pulse_decoder_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender gaps first, receiver stalls harder; short timings and each way to break
        program_regs(4, 3, 32, 36, 4);
        add_frame('0, FRAME_GOOD, 0);
        add_frame(CODE_W'($urandom()), FAIL_IDLE, 0);
        add_frame(CODE_W'($urandom()), FAIL_LEAD, 0);
        add_frame(CODE_W'($urandom()), FAIL_SYNC, 0);
        add_frame(CODE_W'($urandom()), FAIL_BIT_HIGH, 0);
        add_frame(CODE_W'($urandom()), FAIL_BIT_LOW, 0);
        wait_quiet();

        // Swap the gap rates
        send_gap_pct = 57;
        recv_stall_pct = 35;

        // Writes to unused indexes must change nothing
        for (int idx = int'(REG_BIT_TIMEOUT) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), $urandom_range(16'hFFFF, 0));
        end_writes();
        @(negedge i_clk);
        add_frame(CODE_W'($urandom()), FAIL_LEAD, 0);
        wait_quiet();

        // Inverted sync window rejects every sync
        program_regs(6, 3, 40, 33, 4);
        add_random_traffic(3);
        wait_quiet();

        // Smallest limits
        program_regs(1, 1, 1, 1, 1);
        add_random_traffic(3);
        wait_quiet();

        // No gaps on either side
        send_gap_pct = 0;
        recv_stall_pct = 0;
        program_regs(6, 3, 32, 40, 5);
        add_frame(CODE_W'($urandom()), FRAME_GOOD, 0);
        wait_quiet();

        if (mismatches == 0) begin
            $display("PASS rf_remote_pulse_decoder_core");
        end else begin
            $display("FAIL rf_remote_pulse_decoder_core");
        end
        $finish;
    end

endmodule

### files.f
design/rfpd_pkg.sv
design/rfpd_cfg_regs.sv
design/rfpd_decode.sv
design/rfpd_out_buf.sv
design/rf_remote_pulse_decoder_core.sv
design/rfpd_checker.sv
tb/testbench.sv
